// ===== rtl/sct_pkg.sv =====
// Shared types and constants for the Taylor-series sine/cosine block.
`default_nettype none

package sct_pkg;

	// Default number of series terms
	localparam int SCT_SERIES_TERMS = 10;

	// Port field widths
	localparam int SCT_ANGLE_W = 32;
	localparam int SCT_OUT_W   = 32;

	// Shared multiplier: full operand, partial operand and accumulator widths
	localparam int SCT_OPND_W = 36;
	localparam int SCT_PART_W = SCT_OPND_W / 2;
	localparam int SCT_ACC_W  = 2 * SCT_OPND_W;

	// Dividend bound (bits) covered exactly by the reciprocal multiply
	localparam int SCT_DIVN_W = 35;
	localparam int SCT_SHIFT_W = 6;
	localparam int SCT_HALF_W  = 10;

	// Angle constants in Q3.28, one in Q.30
	localparam int SCT_RED_W = SCT_ANGLE_W + 1;
	localparam logic signed [SCT_RED_W-1:0] SCT_PI_Q28     = 33'sd843314857;
	localparam logic signed [SCT_RED_W-1:0] SCT_TWO_PI_Q28 = 33'sd1686629713;
	localparam logic [SCT_OPND_W-1:0]       SCT_ONE_Q30    = 36'd1073741824;

	// Control of the shared multiply-accumulate unit
	typedef struct packed {
		logic en;   // run one pass
		logic hi;   // upper half of b, accumulate shifted
	} sct_mac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/sine_cosine_taylor_series.sv =====
// Top level: fixed-point sine and cosine by Horner-form Taylor series.
//
//  Channel  Direction  Payload (low bit up)                        Transfer when
//  s_axis   in         tdata[31:0] angle (Q3.28)                   tvalid & tready
//  m_axis   out        tdata[31:0] sine_value, [63:32] cosine_value tvalid & tready
//
// A new angle is taken only when the previous one is finished: the angle
// is reduced into [-pi, pi], each of the 4*SERIES_TERMS-2 products takes two
// passes of the single 36x18 multiplier and a finishing step, the output
// register is loaded once it is free, and the idle state takes the next
// transfer.
// Reset clears the sequencer and the output valid. A result held by a stalled
// m_axis does not block the next angle; only a second finished result waits.
`default_nettype none

module sine_cosine_taylor_series #(
	parameter int SERIES_TERMS = sct_pkg::SCT_SERIES_TERMS
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [sct_pkg::SCT_ANGLE_W-1:0]  s_axis_tdata,   // [31:0] angle
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [2*sct_pkg::SCT_OUT_W-1:0]  m_axis_tdata    // [31:0] sine_value,
	                                                          // [63:32] cosine_value
);
	import sct_pkg::*;

	localparam int KW = $clog2(SERIES_TERMS);
	localparam int SINE_W = 41;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RED  = 6'b000010,
		ST_MLO  = 6'b000100,
		ST_MHI  = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		OP_SQ = 2'd0,   // r * r
		OP_PM = 2'd1,   // x2 * h
		OP_DV = 2'd2,   // divide by reciprocal multiply
		OP_SN = 2'd3    // r * h for the sine
	} op_t;

	state_t                     state_q;
	op_t                        op_q;
	logic                       red_cnt_q;
	logic [KW-1:0]              k_q;
	logic                       csel_q;
	logic signed [SCT_RED_W-1:0] r_q;
	logic [SCT_OPND_W-1:0]      x2_q;
	logic [SCT_OPND_W-1:0]      hs_q;
	logic [SCT_OPND_W-1:0]      hc_q;
	logic [SCT_OPND_W-1:0]      n_q;
	logic                       pneg_q;
	logic signed [SINE_W-1:0]   s_q;
	logic                       m_valid_q;
	logic [2*SCT_OUT_W-1:0]     m_data_q;

	// Per-term reciprocal tables
	logic [SCT_OPND_W-1:0]  recip_s [SERIES_TERMS];
	logic [SCT_OPND_W-1:0]  recip_c [SERIES_TERMS];
	logic [SCT_SHIFT_W-1:0] shift_s [SERIES_TERMS];
	logic [SCT_SHIFT_W-1:0] shift_c [SERIES_TERMS];
	logic [SCT_HALF_W-1:0]  half_s  [SERIES_TERMS];
	logic [SCT_HALF_W-1:0]  half_c  [SERIES_TERMS];

	sct_mac_ctl_t          mac_ctl;
	logic [SCT_OPND_W-1:0] mac_a;
	logic [SCT_OPND_W-1:0] mac_b;
	logic [SCT_ACC_W-1:0]  acc;

	logic [SCT_RED_W-1:0]   r_mag;
	logic [SCT_OPND_W-1:0]  h_sel;
	logic [SCT_OPND_W-1:0]  h_mag;
	logic [SCT_OPND_W-1:0]  hs_mag;
	logic [SCT_OPND_W-1:0]  recip_sel;
	logic [SCT_SHIFT_W-1:0] shift_sel;
	logic [SCT_HALF_W-1:0]  half_sel;
	logic [SCT_ACC_W-1:0]   rnd26;
	logic [SCT_ACC_W-1:0]   rnd28;
	logic [SCT_ACC_W-1:0]   rnd30;
	logic [SCT_ACC_W-1:0]   quot_wide;
	logic [SCT_OPND_W-1:0]  quot;
	logic [SCT_OPND_W-1:0]  h_next;
	logic [SINE_W-2:0]      s_mag;
	logic                   s_neg;
	logic                   out_free;

	// Build the reciprocal tables at elaboration; quotient is exact for dividends below 2^35
	for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_tab
		localparam int DS = (g == 0) ? 2 : (2*g) * (2*g + 1);
		localparam int DC = (g == 0) ? 2 : (2*g - 1) * (2*g);
		localparam int SS = SCT_DIVN_W + $clog2(DS);
		localparam int SC = SCT_DIVN_W + $clog2(DC);
		localparam logic [SCT_ACC_W-1:0] MS = ((72'd1 << SS) + DS - 1) / DS;
		localparam logic [SCT_ACC_W-1:0] MC = ((72'd1 << SC) + DC - 1) / DC;
		assign recip_s[g] = MS[SCT_OPND_W-1:0];
		assign recip_c[g] = MC[SCT_OPND_W-1:0];
		assign shift_s[g] = SCT_SHIFT_W'(SS);
		assign shift_c[g] = SCT_SHIFT_W'(SC);
		assign half_s[g]  = SCT_HALF_W'(DS / 2);
		assign half_c[g]  = SCT_HALF_W'(DC / 2);
	end

	function automatic logic [SCT_OUT_W-1:0] sat32(input logic signed [SINE_W-1:0] v);
		logic [SCT_OUT_W-1:0] res;
		if (v > 41'sd2147483647)
			res = 32'h7fff_ffff;
		else if (v < -41'sd2147483648)
			res = 32'h8000_0000;
		else
			res = v[SCT_OUT_W-1:0];
		return res;
	endfunction

	// Magnitudes and per-chain selections
	assign r_mag     = r_q[SCT_RED_W-1] ? SCT_RED_W'(-r_q) : SCT_RED_W'(r_q);
	assign h_sel     = csel_q ? hc_q : hs_q;
	assign h_mag     = h_sel[SCT_OPND_W-1] ? (~h_sel + 1'b1) : h_sel;
	assign hs_mag    = hs_q[SCT_OPND_W-1] ? (~hs_q + 1'b1) : hs_q;
	assign recip_sel = csel_q ? recip_c[k_q] : recip_s[k_q];
	assign shift_sel = csel_q ? shift_c[k_q] : shift_s[k_q];
	assign half_sel  = csel_q ? half_c[k_q]  : half_s[k_q];

	// Operand select for the shared multiplier
	always_comb begin
		mac_a = '0;
		mac_b = '0;
		unique case (op_q)
			OP_SQ: begin
				mac_a = SCT_OPND_W'(r_mag);
				mac_b = SCT_OPND_W'(r_mag);
			end
			OP_PM: begin
				mac_a = x2_q;
				mac_b = h_mag;
			end
			OP_DV: begin
				mac_a = n_q;
				mac_b = recip_sel;
			end
			OP_SN: begin
				mac_a = SCT_OPND_W'(r_mag);
				mac_b = hs_mag;
			end
			default: begin
				mac_a = '0;
				mac_b = '0;
			end
		endcase
	end

	assign mac_ctl.en = (state_q == ST_MLO) || (state_q == ST_MHI);
	assign mac_ctl.hi = (state_q == ST_MHI);

	sct_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (mac_a),
		.b   (mac_b),
		.acc (acc)
	);

	// Round-to-nearest shifts and the Horner update
	assign rnd26     = acc + (72'd1 << 25);
	assign rnd28     = acc + (72'd1 << 27);
	assign rnd30     = acc + (72'd1 << 29);
	assign quot_wide = acc >> shift_sel;
	assign quot      = quot_wide[SCT_OPND_W-1:0];
	assign h_next    = pneg_q ? (SCT_ONE_Q30 + quot) : (SCT_ONE_Q30 - quot);
	assign s_mag     = rnd28[SINE_W-2+28:28];
	assign s_neg     = r_q[SCT_RED_W-1] ^ hs_q[SCT_OPND_W-1];

	assign out_free = !m_valid_q || m_axis_tready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_SQ;
			red_cnt_q <= 1'b0;
			k_q       <= '0;
			csel_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q   <= ST_RED;
						red_cnt_q <= 1'b0;
					end
				end
				ST_RED: begin
					red_cnt_q <= 1'b1;
					if (red_cnt_q) begin
						state_q <= ST_MLO;
						op_q    <= OP_SQ;
					end
				end
				ST_MLO: state_q <= ST_MHI;
				ST_MHI: state_q <= ST_FIN;
				ST_FIN: begin
					unique case (op_q)
						OP_SQ: begin
							state_q <= ST_MLO;
							op_q    <= OP_PM;
							k_q     <= KW'(SERIES_TERMS - 1);
							csel_q  <= 1'b0;
						end
						OP_PM: begin
							state_q <= ST_MLO;
							op_q    <= OP_DV;
						end
						OP_DV: begin
							state_q <= ST_MLO;
							csel_q  <= ~csel_q;
							if (csel_q && k_q == KW'(1)) begin
								op_q <= OP_SN;
							end else begin
								op_q <= OP_PM;
								if (csel_q)
									k_q <= k_q - KW'(1);
							end
						end
						OP_SN: state_q <= ST_OUT;
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid)
			r_q <= {s_axis_tdata[SCT_ANGLE_W-1], s_axis_tdata};
		if (state_q == ST_RED) begin
			if (r_q > SCT_PI_Q28)
				r_q <= r_q - SCT_TWO_PI_Q28;
			else if (r_q < -SCT_PI_Q28)
				r_q <= r_q + SCT_TWO_PI_Q28;
		end
		if (state_q == ST_FIN) begin
			unique case (op_q)
				OP_SQ: begin
					x2_q <= rnd26[SCT_OPND_W-1+26:26];
					hs_q <= SCT_ONE_Q30;
					hc_q <= SCT_ONE_Q30;
				end
				OP_PM: begin
					n_q    <= rnd30[SCT_OPND_W-1+30:30] + SCT_OPND_W'(half_sel);
					pneg_q <= h_sel[SCT_OPND_W-1];
				end
				OP_DV: begin
					if (csel_q)
						hc_q <= h_next;
					else
						hs_q <= h_next;
				end
				OP_SN: s_q <= s_neg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
				default: s_q <= s_q;
			endcase
		end
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free)
			m_data_q <= {sat32(SINE_W'($signed(hc_q))), sat32(s_q)};
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// ===== rtl/sct_mac.sv =====
// Shared two-pass unsigned multiplier with accumulator.
`default_nettype none

module sct_mac (
	input  wire                                clk,
	input  wire  sct_pkg::sct_mac_ctl_t        ctl,
	input  wire  [sct_pkg::SCT_OPND_W-1:0]     a,
	input  wire  [sct_pkg::SCT_OPND_W-1:0]     b,
	output logic [sct_pkg::SCT_ACC_W-1:0]      acc
);
	import sct_pkg::*;

	logic [SCT_PART_W-1:0]            b_part;
	logic [SCT_OPND_W+SCT_PART_W-1:0] prod;
	logic [SCT_ACC_W-1:0]             acc_q;

	// Select the half of b for this pass
	assign b_part = ctl.hi ? b[SCT_OPND_W-1:SCT_PART_W] : b[SCT_PART_W-1:0];
	assign prod   = a * b_part;

	// Load low partial product, then add the shifted high one
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.hi)
				acc_q <= acc_q + {prod, {SCT_PART_W{1'b0}}};
			else
				acc_q <= {{(SCT_ACC_W-SCT_OPND_W-SCT_PART_W){1'b0}}, prod};
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ===== tb/sine_cosine_taylor_series_tb.sv =====
// Testbench for the Taylor-series sine/cosine block: predicts and checks every result.
module sine_cosine_taylor_series_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TERMS = sct_pkg::SCT_SERIES_TERMS;
	localparam int RANDOM_ANGLES = 1050;
	localparam longint unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned LONG_HOLD_AT = 300;
	localparam int unsigned LONG_HOLD_CYCLES = 1500;
	localparam int DRAIN_CYCLES = 250;

	// One result transfer: sine in the low word, cosine in the high word
	typedef struct packed {
		logic signed [31:0] cosine;
		logic signed [31:0] sine;
	} trig_pair_t;

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} sink_mode_t;

	class trig_scoreboard;
		localparam longint PI_Q28 = longint'(sct_pkg::SCT_PI_Q28);
		localparam longint TWO_PI_Q28 = longint'(sct_pkg::SCT_TWO_PI_Q28);
		localparam longint ONE_Q30 = longint'(sct_pkg::SCT_ONE_Q30);

		trig_pair_t expected_trig[$];
		int unsigned mismatches = 0;
		int unsigned results_seen = 0;

		// Product shifted right, rounded to nearest, ties away from zero
		function longint mul_round(longint a, longint b, int sh);
			bit neg;
			longint unsigned p;
			neg = (a < 0) != (b < 0);
			p = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
			p = (p + (64'd1 << (sh - 1))) >> sh;
			return neg ? -longint'(p) : longint'(p);
		endfunction

		// Quotient by a positive divisor, rounded the same way
		function longint div_round(longint a, longint d);
			longint q;
			q = ((a < 0 ? -a : a) + d / 2) / d;
			return a < 0 ? -q : q;
		endfunction

		function logic signed [31:0] clamp_q130(longint v);
			if (v > 64'sd2147483647) return 32'sh7fffffff;
			if (v < -64'sd2147483648) return 32'sh80000000;
			return v[31:0];
		endfunction

		// Reduce the angle into [-pi, pi], then run both Horner series
		function trig_pair_t predict_trig(logic [31:0] angle);
			longint r, x2, h_sin, h_cos, d_sin, d_cos;
			int k;
			trig_pair_t res;
			r = longint'($signed(angle));
			repeat (2) begin
				if (r > PI_Q28) r -= TWO_PI_Q28;
				else if (r < -PI_Q28) r += TWO_PI_Q28;
			end
			x2 = mul_round(r, r, 26);
			h_sin = ONE_Q30;
			h_cos = ONE_Q30;
			for (k = TERMS - 1; k >= 1; k--) begin
				d_sin = longint'(2 * k) * longint'(2 * k + 1);
				d_cos = longint'(2 * k - 1) * longint'(2 * k);
				h_sin = ONE_Q30 - div_round(mul_round(x2, h_sin, 30), d_sin);
				h_cos = ONE_Q30 - div_round(mul_round(x2, h_cos, 30), d_cos);
			end
			res.sine = clamp_q130(mul_round(r, h_sin, 28));
			res.cosine = clamp_q130(h_cos);
			return res;
		endfunction

		function void note_angle(logic [31:0] angle);
			expected_trig.push_back(predict_trig(angle));
		endfunction

		function void check_result(logic [63:0] data);
			trig_pair_t got, want;
			got = data;
			results_seen++;
			if (expected_trig.size() == 0) begin
				$display("%0t: result with none expected: sine %0d cosine %0d",
					$time, got.sine, got.cosine);
				mismatches++;
				return;
			end
			want = expected_trig.pop_front();
			if (got.sine !== want.sine) begin
				$display("%0t: sine mismatch: expected %0d actual %0d",
					$time, want.sine, got.sine);
				mismatches++;
			end
			if (got.cosine !== want.cosine) begin
				$display("%0t: cosine mismatch: expected %0d actual %0d",
					$time, want.cosine, got.cosine);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;

	trig_scoreboard sb = new();

	sine_cosine_taylor_series #(
		.SERIES_TERMS(TERMS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one angle and hold it until the transfer
	task automatic send_angle(input logic [31:0] angle);
		s_axis_tdata <= angle;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_angle(angle);
	endtask

	// Mix full-range and in-range angles with ones near the reduction edges and near zero
	function automatic logic [31:0] pick_angle();
		int unsigned sel;
		longint pi, v;
		sel = $urandom_range(0, 99);
		pi = longint'(sct_pkg::SCT_PI_Q28);
		if (sel < 45) begin
			v = longint'($urandom);
		end else if (sel < 65) begin
			v = longint'($urandom_range(0, 2 * 843314857)) - pi;
		end else if (sel < 85) begin
			case ($urandom_range(0, 3))
				0: v = pi;
				1: v = -pi;
				2: v = longint'(sct_pkg::SCT_TWO_PI_Q28);
				default: v = -longint'(sct_pkg::SCT_TWO_PI_Q28);
			endcase
			v += longint'($urandom_range(0, 128)) - 64;
		end else begin
			v = longint'($signed($urandom) >>> $urandom_range(4, 30));
		end
		return v[31:0];
	endfunction

	// Drive angles: directed edges first, then random bursts
	initial begin : angle_source
		logic [31:0] directed[$];
		int unsigned burst_left;
		directed = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 32'd843314857, 32'd843314858,
			32'd843314856, -32'sd843314857, -32'sd843314858, -32'sd843314856,
			32'd1686629713, -32'sd1686629713, 32'd421657428, -32'sd421657428,
			32'h5555_5555, 32'haaaa_aaaa, 32'd2529944570, -32'sd2529944570};
		burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_angle(directed[i]);
		for (int n = 0; n < RANDOM_ANGLES; n++) begin
			if (burst_left == 0) begin
				s_axis_tvalid <= 1'b0;
				s_axis_tdata <= $urandom;
				repeat ($urandom_range(1, 150)) @(posedge clk);
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
			send_angle(pick_angle());
		end
		s_axis_tvalid <= 1'b0;
		while (sb.expected_trig.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Take results; stall in random phases, with one long hold-off to back up the input
	initial begin : result_sink
		sink_mode_t mode;
		int unsigned phase_left, hold_left, sink_cycle;
		bit long_hold_done;
		mode = SINK_OPEN;
		phase_left = 0;
		hold_left = 0;
		sink_cycle = 0;
		long_hold_done = 1'b0;
		forever begin
			@(posedge clk);
			sink_cycle++;
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if (!long_hold_done && sb.results_seen >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					mode = sink_mode_t'($urandom_range(0, 3));
					phase_left = $urandom_range(20, 200);
				end
				phase_left--;
				case (mode)
					SINK_OPEN:   m_axis_tready <= 1'b1;
					SINK_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
					SINK_SPARSE: m_axis_tready <= (sink_cycle[1:0] == 2'd0);
					default:     m_axis_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// Stop a hung run
	initial begin : watchdog
		longint unsigned cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

endmodule

// ===== files.f =====
rtl/sct_pkg.sv
rtl/sct_mac.sv
rtl/sine_cosine_taylor_series.sv
tb/sine_cosine_taylor_series_tb.sv
